// ===== rtl/assert_macros.svh =====
// Assertion macros used by the sequencer of the integer to ASCII converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define ITA_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed: %m");

// Condition that must never be true outside of reset.
`define ITA_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("forbidden condition: %m");

`endif

// ===== rtl/ita_pkg.sv =====
// Shared types and constants of the integer to ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package ita_pkg;

   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_BIN = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;

   localparam logic [1:0] CSR_RADIX      = 2'd0;
   localparam logic [1:0] CSR_MIN_DIGITS = 2'd1;
   localparam logic [1:0] CSR_PAD_CHAR   = 2'd2;

   localparam int         CNT_W      = 6;
   localparam logic [5:0] MAX_WIDTH  = 6'd32;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] PAD_RESET  = 8'h20;

   localparam logic [7:0] DIGIT_CHARS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
   };

   typedef struct packed {
      logic load;
      logic conv;
      logic shift;
   } ctl_type;

   typedef struct packed {
      logic       negative;
      logic [3:0] top_digit;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/integer_to_ascii_radix.sv =====
// Top level of the integer to ASCII converter: register file and unit wiring.
// A request is taken in the idle state, then a minus sign is sent for a negative value, the
// value is converted bit-serially to BCD in decimal, leading zero digits are skipped, and
// the pad and digit characters are sent, each waiting while the output register is full.
// A new request is not taken before the last character has entered the output register.
// Reset is synchronous; it empties the output.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_radix #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // value[31:0]
   input  wire logic        req_tuser,   // is_signed
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // char_out[7:0]
   output logic             rsp_tlast    // last_char
);

   logic [1:0]       radix_ff;
   logic [1:0]       radix_in;
   logic [5:0]       min_digits_ff;
   logic [5:0]       min_digits_in;
   logic [7:0]       pad_char_ff;
   logic [7:0]       pad_char_in;
   ita_pkg::ctl_type ctl;
   ita_pkg::sts_type sts;

   always_comb begin
      radix_in      = radix_ff;
      min_digits_in = min_digits_ff;
      pad_char_in   = pad_char_ff;
      if (csr_we) begin
         case (csr_index)
            ita_pkg::CSR_RADIX:      radix_in      = csr_wdata[1:0];
            ita_pkg::CSR_MIN_DIGITS: min_digits_in = csr_wdata[5:0];
            ita_pkg::CSR_PAD_CHAR:   pad_char_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= ita_pkg::RADIX_DEC;
         min_digits_ff <= '0;
         pad_char_ff   <= ita_pkg::PAD_RESET;
      end else begin
         radix_ff      <= radix_in;
         min_digits_ff <= min_digits_in;
         pad_char_ff   <= pad_char_in;
      end
   end

   ita_digits #(
      .VALUE_BITS (VALUE_BITS)
   ) u_digits (
      .clock     (clock),
      .value     (req_tdata),
      .is_signed (req_tuser),
      .radix     (radix_ff),
      .ctl       (ctl),
      .sts       (sts)
   );

   ita_seq #(
      .VALUE_BITS (VALUE_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .radix      (radix_ff),
      .min_digits (min_digits_ff),
      .pad_char   (pad_char_ff),
      .sts        (sts),
      .ctl        (ctl)
   );

endmodule

`default_nettype wire

// ===== rtl/ita_digits.sv =====
// Digit shift registers: magnitude, bit-serial BCD conversion and digit shift-out.
`timescale 1ns / 1ps
`default_nettype none

module ita_digits #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic            clock,
   input  wire logic [31:0]     value,
   input  wire logic            is_signed,
   input  wire logic [1:0]      radix,
   input  wire ita_pkg::ctl_type ctl,
   output ita_pkg::sts_type     sts
);

   localparam int MAG_W  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int EXT_W  = (VALUE_BITS > 32) ? VALUE_BITS : 32;
   localparam int NDEC   = (MAG_W * 302 + 999) / 1000;
   localparam int HEX_D  = (MAG_W + 3) / 4;
   localparam int NHEX   = (HEX_D > NDEC) ? HEX_D : NDEC;
   localparam int NUM_W  = 4 * NHEX;
   localparam int BCD_W  = 4 * NDEC;
   localparam int SH_BIN = NUM_W - MAG_W;
   localparam int SH_HEX = NUM_W - 4 * HEX_D;
   localparam int SH_BCD = NUM_W - BCD_W;

   logic [MAG_W-1:0]      mag_ff;
   logic [MAG_W-1:0]      mag_in;
   logic [NUM_W-1:0]      num_ff;
   logic [NUM_W-1:0]      num_in;
   logic [EXT_W-1:0]      value_ext;
   logic [VALUE_BITS-1:0] value_fit;
   logic [VALUE_BITS-1:0] value_abs;
   logic                  negative;
   logic [BCD_W-1:0]      bcd;
   logic [BCD_W-1:0]      bcd_adj;
   logic                  is_bin;
   logic                  is_hex;

   assign is_bin    = (radix == ita_pkg::RADIX_BIN);
   assign is_hex    = (radix == ita_pkg::RADIX_HEX);
   assign value_ext = EXT_W'(value);
   assign value_fit = value_ext[VALUE_BITS-1:0];
   assign negative  = is_signed & value_fit[VALUE_BITS-1];
   assign value_abs = negative ? (~value_fit + 1'b1) : value_fit;
   assign bcd       = num_ff[NUM_W-1 -: BCD_W];

   always_comb begin
      for (int i = 0; i < NDEC; i++) begin
         bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3)
                                                      : bcd[4*i +: 4];
      end
   end

   always_comb begin
      mag_in = mag_ff;
      num_in = num_ff;
      if (ctl.load) begin
         mag_in = value_abs[MAG_W-1:0];
         if (is_bin) begin
            num_in = NUM_W'(value_abs[MAG_W-1:0]) << SH_BIN;
         end else if (is_hex) begin
            num_in = NUM_W'(value_abs[MAG_W-1:0]) << SH_HEX;
         end else begin
            num_in = '0;
         end
      end else if (ctl.conv) begin
         mag_in = mag_ff << 1;
         num_in = NUM_W'({bcd_adj[BCD_W-2:0], mag_ff[MAG_W-1]}) << SH_BCD;
      end else if (ctl.shift) begin
         num_in = is_bin ? (num_ff << 1) : (num_ff << 4);
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      num_ff <= num_in;
   end

   assign sts.negative  = negative;
   assign sts.top_digit = is_bin ? {3'b000, num_ff[NUM_W-1]} : num_ff[NUM_W-1 -: 4];

endmodule

`default_nettype wire

// ===== rtl/ita_seq.sv =====
// Sequencer: sign, conversion, zero skip, padding and digit emission, with the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ita_seq #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [1:0]       radix,
   input  wire logic [5:0]       min_digits,
   input  wire logic [7:0]       pad_char,
   input  wire ita_pkg::sts_type sts,
   output ita_pkg::ctl_type      ctl
);

   localparam int MAG_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int NDEC  = (MAG_W * 302 + 999) / 1000;
   localparam int HEX_D = (MAG_W + 3) / 4;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SIGN  = 6'b000010,
      ST_CONV  = 6'b000100,
      ST_SKIP  = 6'b001000,
      ST_PAD   = 6'b010000,
      ST_DIGIT = 6'b100000
   } state_type;

   state_type                  state_ff;
   state_type                  state_in;
   logic [ita_pkg::CNT_W-1:0]  cnt_ff;
   logic [ita_pkg::CNT_W-1:0]  cnt_in;
   logic [5:0]                 pad_ff;
   logic [5:0]                 pad_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [7:0]                 rsp_char_ff;
   logic [7:0]                 rsp_char_in;
   logic                       rsp_last_ff;
   logic                       rsp_last_in;
   logic                       out_free;
   logic                       emit;
   logic [7:0]                 emit_char;
   logic                       emit_last;
   logic                       is_dec;
   logic [5:0]                 width;

   assign is_dec   = (radix != ita_pkg::RADIX_BIN) && (radix != ita_pkg::RADIX_HEX);
   assign width    = (min_digits > ita_pkg::MAX_WIDTH) ? ita_pkg::MAX_WIDTH : min_digits;
   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pad_in    = pad_ff;
      ctl       = '0;
      emit      = 1'b0;
      emit_char = '0;
      emit_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl.load = 1'b1;
               cnt_in = (radix == ita_pkg::RADIX_HEX) ? ita_pkg::CNT_W'(HEX_D)
                                                      : ita_pkg::CNT_W'(MAG_W);
               if (sts.negative) begin
                  state_in = ST_SIGN;
               end else if (is_dec) begin
                  state_in = ST_CONV;
               end else begin
                  state_in = ST_SKIP;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = ita_pkg::CHAR_MINUS;
               state_in  = is_dec ? ST_CONV : ST_SKIP;
            end
         end
         ST_CONV: begin
            ctl.conv = 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == ita_pkg::CNT_W'(1)) begin
               cnt_in   = ita_pkg::CNT_W'(NDEC);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if ((sts.top_digit == 4'd0) && (cnt_ff > ita_pkg::CNT_W'(1))) begin
               ctl.shift = 1'b1;
               cnt_in    = cnt_ff - 1'b1;
            end else if (width > cnt_ff) begin
               pad_in   = width - cnt_ff;
               state_in = ST_PAD;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_PAD: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = pad_char;
               pad_in    = pad_ff - 1'b1;
               if (pad_ff == 6'd1) begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = ita_pkg::DIGIT_CHARS[sts.top_digit];
               emit_last = (cnt_ff == ita_pkg::CNT_W'(1));
               ctl.shift = 1'b1;
               cnt_in    = cnt_ff - 1'b1;
               if (cnt_ff == ita_pkg::CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit | (rsp_valid_ff & ~rsp_tready);
   assign rsp_char_in  = emit ? emit_char : rsp_char_ff;
   assign rsp_last_in  = emit ? emit_last : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      pad_ff      <= pad_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ITA_ASSERT(a_last_ends_request, (emit && emit_last) |=> (state_ff == ST_IDLE))
   `ITA_ASSERT(a_digit_count_live, (state_ff == ST_DIGIT) |-> (cnt_ff != '0))
   `ITA_ASSERT(a_pad_in_range, (state_ff == ST_PAD) |-> ((pad_ff != '0) && (pad_ff <= ita_pkg::MAX_WIDTH)))
   `ITA_NEVER(a_no_overwrite, emit && rsp_valid_ff && !rsp_tready)

endmodule

`default_nettype wire

// ===== sim/integer_to_ascii_radix_tb.sv =====
// Testbench of the integer to ASCII converter: random and directed numbers, checked per character.
`timescale 1ns / 1ps

module integer_to_ascii_radix_tb;

   localparam int         VALUE_BITS   = 32;
   localparam logic [1:0] RADIX_UNUSED = 2'd3;
   localparam logic [7:0] CHAR_STAR    = 8'h2a;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;

   typedef struct packed {
      logic [31:0] value;
      logic        sgn;
   } number_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // value[31:0]
   logic        req_tuser = 1'b0; // is_signed
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // char_out[7:0]
   logic        rsp_tlast;        // last_char

   number_type    numbers_to_send[$];
   text_char_type expected_text[$];
   number_type    next_number;
   text_char_type got_char;
   text_char_type want_char;
   logic [1:0] fmt_radix = ita_pkg::RADIX_DEC;
   logic [5:0] fmt_min_digits = '0;
   logic [7:0] fmt_pad = ita_pkg::PAD_RESET;
   logic       req_taken = 1'b0;
   logic       calm = 1'b0;
   int         mismatches = 0;

   integer_to_ascii_radix #(.VALUE_BITS(VALUE_BITS)) dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Renders one number with the current format into the expected character stream.
   task automatic render_number(input logic [31:0] bits, input logic sgn);
      logic [31:0] mag;
      int unsigned base;
      logic [3:0]  digs[64];
      int          nd;
      int          width;
      mag = bits;
      if (sgn && mag[VALUE_BITS-1]) begin
         expected_text.push_back('{ch: ita_pkg::CHAR_MINUS, last: 1'b0});
         mag = -mag;
      end
      case (fmt_radix)
         ita_pkg::RADIX_BIN: base = 2;
         ita_pkg::RADIX_HEX: base = 16;
         default: base = 10;
      endcase
      nd = 0;
      do begin
         digs[nd] = 4'(mag % base);
         nd++;
         mag = mag / base;
      end while (mag != 0);
      width = (fmt_min_digits > ita_pkg::MAX_WIDTH) ? int'(ita_pkg::MAX_WIDTH)
                                                    : int'(fmt_min_digits);
      for (int i = nd; i < width; i++)
         expected_text.push_back('{ch: fmt_pad, last: 1'b0});
      for (int i = nd; i > 0; i--)
         expected_text.push_back('{ch: ita_pkg::DIGIT_CHARS[digs[i-1]], last: (i == 1)});
   endtask

   always @(posedge clock) begin
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken)
         render_number(req_tdata, req_tuser);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_char = '{ch: rsp_tdata, last: rsp_tlast};
         if (expected_text.size() == 0) begin
            $error("unexpected character %h with no request pending", rsp_tdata);
            mismatches++;
         end else begin
            want_char = expected_text.pop_front();
            if (got_char.ch !== want_char.ch) begin
               $error("char_out mismatch: expected %h, actual %h", want_char.ch, got_char.ch);
               mismatches++;
            end
            if (got_char.last !== want_char.last) begin
               $error("last_char mismatch: expected %b, actual %b", want_char.last,
                      got_char.last);
               mismatches++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (numbers_to_send.size() > 0 && (calm || $urandom_range(0, 99) >= 20)) begin
            next_number = numbers_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_number.value;
            req_tuser  <= next_number.sgn;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      if (!reset)
         rsp_tready <= calm || ($urandom_range(0, 99) >= 20);
   end

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         ita_pkg::CSR_RADIX:      fmt_radix = data[1:0];
         ita_pkg::CSR_MIN_DIGITS: fmt_min_digits = data[5:0];
         ita_pkg::CSR_PAD_CHAR:   fmt_pad = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_format(input logic [7:0] radix, input logic [7:0] width,
                             input logic [7:0] pad);
      write_reg(ita_pkg::CSR_RADIX, radix);
      write_reg(ita_pkg::CSR_MIN_DIGITS, width);
      write_reg(ita_pkg::CSR_PAD_CHAR, pad);
   endtask

   task automatic send(input logic [31:0] value, input logic sgn);
      numbers_to_send.push_back('{value: value, sgn: sgn});
   endtask

   // Waits until every request has been taken and its text has come out, then lets
   // the block run dry before the format may change.
   task automatic settle();
      while (numbers_to_send.size() != 0 || req_tvalid || expected_text.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = $urandom_range(0, 20);
         2: v = 32'h7fff_fffe + $urandom_range(0, 3);
         3: v = 32'hffff_ffff - $urandom_range(0, 20);
         default: v = $urandom >> $urandom_range(0, 31);
      endcase
      return v;
   endfunction

   function automatic logic [7:0] pick_width();
      logic [7:0] w;
      case ($urandom_range(0, 3))
         0: w = 8'd0;
         1: w = 8'($urandom_range(1, 32));
         2: w = 8'($urandom_range(33, 255));
         default: w = 8'd32;
      endcase
      return w;
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset format: decimal, no padding, space pad.
      send(32'd0, 1'b0);
      send(32'hffff_ffff, 1'b0);
      send(32'hffff_ffff, 1'b1);
      send(32'h8000_0000, 1'b1);
      send(32'h7fff_ffff, 1'b1);
      send(32'h8000_0000, 1'b0);
      send(32'd12345, 1'b1);
      settle();

      // Binary at the widest field, including the most negative value.
      set_format(8'(ita_pkg::RADIX_BIN), 8'(ita_pkg::MAX_WIDTH), CHAR_ZERO);
      send(32'd0, 1'b0);
      send(32'hffff_ffff, 1'b0);
      send(32'h8000_0000, 1'b1);
      send(32'd5, 1'b1);
      settle();

      // Hexadecimal with an oversized width that saturates.
      set_format(8'(ita_pkg::RADIX_HEX), 8'd63, CHAR_STAR);
      send(32'hdead_beef, 1'b0);
      send(32'hffff_ffff, 1'b1);
      send(32'h0000_00a0, 1'b0);
      settle();

      // The unused radix code prints decimal; pad bytes at both extremes.
      set_format(8'(RADIX_UNUSED), 8'd10, 8'h00);
      send(32'd42, 1'b0);
      send(-32'sd42, 1'b1);
      settle();
      set_format(8'(ita_pkg::RADIX_DEC), 8'd3, 8'hff);
      send(32'd7, 1'b1);
      send(32'd123456, 1'b0);
      settle();

      for (int phase = 0; phase < 8; phase++) begin
         set_format(8'($urandom_range(0, 255)), pick_width(), 8'($urandom_range(0, 255)));
         calm = (phase == 3);
         for (int k = 0; k < 28; k++)
            send(pick_value(), 1'($urandom_range(0, 1)));
         settle();
      end

      calm = 1'b0;
      settle();
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== integer_to_ascii_radix.f =====
+incdir+rtl
rtl/ita_pkg.sv
rtl/ita_digits.sv
rtl/ita_seq.sv
rtl/integer_to_ascii_radix.sv
sim/integer_to_ascii_radix_tb.sv
